[src/xbr_pkg.sv]
// Package for the XMODEM block receiver: protocol byte codes, phase encoding,
// queue item and result types, and the CRC-16/XMODEM byte update.
// No dependencies.
`default_nettype none

package xbr_pkg;

  // Protocol bytes
  localparam logic [7:0] BYTE_SOH        = 8'h01;
  localparam logic [7:0] BYTE_EOT        = 8'h04;
  localparam logic [7:0] BYTE_ACK        = 8'h06;
  localparam logic [7:0] BYTE_NAK        = 8'h15;
  localparam logic [7:0] BYTE_CAN        = 8'h18;
  localparam logic [7:0] BYTE_INVITE_CRC = 8'h43;
  localparam logic [7:0] BYTE_PAD        = 8'd26;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Link status codes
  localparam logic [1:0] LINK_RUNNING   = 2'd0;
  localparam logic [1:0] LINK_EOT       = 2'd1;
  localparam logic [1:0] LINK_CANCELLED = 2'd2;
  localparam logic [1:0] LINK_FAILED    = 2'd3;

  // Input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Register indexes on the config port
  localparam logic REG_CRC_MODE = 1'b0;
  localparam logic REG_TRIES    = 1'b1;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_HANDSHAKE = 8'b0000_0010,
    PH_HEADER    = 8'b0000_0100,
    PH_NUMBER    = 8'b0000_1000,
    PH_COMPL     = 8'b0001_0000,
    PH_DATA      = 8'b0010_0000,
    PH_CHECK_HI  = 8'b0100_0000,
    PH_CHECK_LO  = 8'b1000_0000
  } phase_e;

  // Classified input item
  typedef struct packed {
    logic       start;
    logic [7:0] rx_byte;
    logic       is_soh;
    logic       is_eot;
    logic       is_can;
    logic       is_pad;
  } item_t;

  typedef struct packed {
    logic       crc_mode;
    logic [3:0] handshake_tries;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_is_padding;
    logic       block_end;
    logic       block_good;
    logic [7:0] block_number;
    logic [1:0] link_status;
  } res_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[src/xbr_if.sv]
// Valid/ready channel interfaces for the XMODEM block receiver:
// the input item channel and the result channel. No dependencies.
`default_nettype none

interface xbr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface xbr_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       data_is_padding;
  logic       block_end;
  logic       block_good;
  logic [7:0] block_number;
  logic [1:0] link_status;

  modport source (output valid, output tx_valid, output tx_byte, output data_valid,
                  output data_byte, output data_is_padding, output block_end,
                  output block_good, output block_number, output link_status,
                  input ready);
  modport sink   (input valid, input tx_valid, input tx_byte, input data_valid,
                  input data_byte, input data_is_padding, input block_end,
                  input block_good, input block_number, input link_status,
                  output ready);
endinterface

`default_nettype wire

[src/xbr_front.sv]
// Front end: accepts input items, classifies the byte and holds them in a
// two-entry queue for the back end. Depends on xbr_pkg.
`default_nettype none

module xbr_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic           in_opcode_i,
  input  wire logic [7:0]     in_byte_i,
  output logic                item_valid_o,
  output xbr_pkg::item_t      item_o,
  input  wire logic           item_pop_i
);

  xbr_pkg::item_t                 entry_q [xbr_pkg::Q_DEPTH];
  logic [xbr_pkg::Q_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [xbr_pkg::Q_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [xbr_pkg::Q_CNT_W-1:0]    count_q, count_d;
  xbr_pkg::item_t                 item_new;
  logic                           push;

  // Classify the incoming byte
  always_comb begin
    item_new.start   = (in_opcode_i == xbr_pkg::OP_START);
    item_new.rx_byte = in_byte_i;
    item_new.is_soh  = (in_byte_i == xbr_pkg::BYTE_SOH);
    item_new.is_eot  = (in_byte_i == xbr_pkg::BYTE_EOT);
    item_new.is_can  = (in_byte_i == xbr_pkg::BYTE_CAN);
    item_new.is_pad  = (in_byte_i == xbr_pkg::BYTE_PAD);
  end

  assign in_ready_o   = (count_q != xbr_pkg::Q_CNT_W'(xbr_pkg::Q_DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (count_q != '0);
  assign item_o       = entry_q[rd_ptr_q];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (item_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !item_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && item_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

[src/xbr_back.sv]
// Back end: the XMODEM protocol sequencer with CRC/checksum and the result
// output register. Depends on xbr_pkg.
`default_nettype none

module xbr_back #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire xbr_pkg::cfg_t  cfg_i,
  input  wire logic           item_valid_i,
  input  wire xbr_pkg::item_t item_i,
  output logic                item_pop_o,
  output logic                res_valid_o,
  output xbr_pkg::res_t       res_o,
  input  wire logic           res_ready_i
);

  localparam int unsigned IdxW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BLOCK_BYTES - 1);

  xbr_pkg::phase_e phase_q, phase_d;
  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      frame_number_q, frame_number_d;
  logic            number_ok_q, number_ok_d;
  logic [7:0]      crc_high_q, crc_high_d;
  logic [3:0]      tries_q, tries_d;
  logic            out_valid_q, out_valid_d;
  xbr_pkg::res_t   out_q, out_d;
  xbr_pkg::res_t   res;
  logic            res_load;
  logic            check_ok;
  logic            good;
  logic [7:0]      invite;

  // Take the next item whenever the output register can hold a result
  assign item_pop_o = item_valid_i && (!out_valid_q || res_ready_i);
  assign invite     = cfg_i.crc_mode ? xbr_pkg::BYTE_INVITE_CRC : xbr_pkg::BYTE_NAK;

  // Check compare for the verdict byte
  always_comb begin
    if (phase_q == xbr_pkg::PH_CHECK_LO) begin
      check_ok = ({crc_high_q, item_i.rx_byte} == crc_q);
    end else begin
      check_ok = (item_i.rx_byte == sum_q);
    end
    good = number_ok_q && check_ok;
  end

  // Protocol sequencer
  always_comb begin
    phase_d        = phase_q;
    byte_index_d   = byte_index_q;
    crc_d          = crc_q;
    sum_d          = sum_q;
    frame_number_d = frame_number_q;
    number_ok_d    = number_ok_q;
    crc_high_d     = crc_high_q;
    tries_d        = tries_q;
    res            = '0;
    res_load       = 1'b0;
    if (item_pop_o) begin
      if (item_i.start) begin
        phase_d        = xbr_pkg::PH_HANDSHAKE;
        byte_index_d   = '0;
        crc_d          = '0;
        sum_d          = '0;
        frame_number_d = '0;
        number_ok_d    = 1'b0;
        crc_high_d     = '0;
        tries_d        = 4'd1;
        res.tx_valid   = 1'b1;
        res.tx_byte    = invite;
        res_load       = 1'b1;
      end else begin
        case (phase_q)
          xbr_pkg::PH_HANDSHAKE: begin
            if (item_i.is_soh) begin
              crc_d   = '0;
              sum_d   = '0;
              phase_d = xbr_pkg::PH_NUMBER;
            end else if (tries_q >= cfg_i.handshake_tries) begin
              phase_d         = xbr_pkg::PH_IDLE;
              res.link_status = xbr_pkg::LINK_FAILED;
              res_load        = 1'b1;
            end else begin
              tries_d      = tries_q + 4'd1;
              res.tx_valid = 1'b1;
              res.tx_byte  = invite;
              res_load     = 1'b1;
            end
          end
          xbr_pkg::PH_HEADER: begin
            if (item_i.is_soh) begin
              crc_d   = '0;
              sum_d   = '0;
              phase_d = xbr_pkg::PH_NUMBER;
            end else if (item_i.is_eot || item_i.is_can) begin
              res.tx_valid    = 1'b1;
              res.tx_byte     = xbr_pkg::BYTE_ACK;
              res.link_status = item_i.is_eot ? xbr_pkg::LINK_EOT
                                              : xbr_pkg::LINK_CANCELLED;
              res_load        = 1'b1;
              phase_d         = xbr_pkg::PH_IDLE;
            end
          end
          xbr_pkg::PH_NUMBER: begin
            frame_number_d = item_i.rx_byte;
            phase_d        = xbr_pkg::PH_COMPL;
          end
          xbr_pkg::PH_COMPL: begin
            number_ok_d  = (item_i.rx_byte == ~frame_number_q);
            byte_index_d = '0;
            phase_d      = xbr_pkg::PH_DATA;
          end
          xbr_pkg::PH_DATA: begin
            crc_d               = xbr_pkg::crc_byte(crc_q, item_i.rx_byte);
            sum_d               = sum_q + item_i.rx_byte;
            res.data_valid      = 1'b1;
            res.data_byte       = item_i.rx_byte;
            res.data_is_padding = item_i.is_pad;
            res_load            = 1'b1;
            if (byte_index_q == LastIdx) begin
              byte_index_d = '0;
              phase_d      = xbr_pkg::PH_CHECK_HI;
            end else begin
              byte_index_d = byte_index_q + 1'b1;
            end
          end
          xbr_pkg::PH_CHECK_HI, xbr_pkg::PH_CHECK_LO: begin
            if (phase_q == xbr_pkg::PH_CHECK_HI && cfg_i.crc_mode) begin
              crc_high_d = item_i.rx_byte;
              phase_d    = xbr_pkg::PH_CHECK_LO;
            end else begin
              // verdict: one ACK or NAK with the block flags
              res.tx_valid     = 1'b1;
              res.tx_byte      = good ? xbr_pkg::BYTE_ACK : xbr_pkg::BYTE_NAK;
              res.block_end    = 1'b1;
              res.block_good   = good;
              res.block_number = frame_number_q;
              res_load         = 1'b1;
              phase_d          = xbr_pkg::PH_HEADER;
            end
          end
          default: begin
            // idle: bytes are dropped
          end
        endcase
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_load) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= xbr_pkg::PH_IDLE;
      byte_index_q   <= '0;
      crc_q          <= '0;
      sum_q          <= '0;
      frame_number_q <= '0;
      number_ok_q    <= 1'b0;
      crc_high_q     <= '0;
      tries_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      phase_q        <= phase_d;
      byte_index_q   <= byte_index_d;
      crc_q          <= crc_d;
      sum_q          <= sum_d;
      frame_number_q <= frame_number_d;
      number_ok_q    <= number_ok_d;
      crc_high_q     <= crc_high_d;
      tries_q        <= tries_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

[src/xmodem_block_receiver_unit.sv]
// Top level of the XMODEM block receiver: config registers on an APB-style
// port, front classifier/queue and back protocol sequencer.
// Depends on xbr_pkg, xbr_if, xbr_front and xbr_back.
//
//   channel  | dir | transfer when      | payload
//   in_if    | in  | valid && ready     | opcode, rx_byte
//   out_if   | out | valid && ready     | tx/data/block fields, link_status
//   apb      | in  | psel&penable&pwrite| paddr, pwdata (prdata on reads)
//
// One item per cycle sustained unless the output stalls; the sequencer
// updates CRC and sum for a byte as it takes the byte. An item waits in
// the queue, and its result in the output register.
// Reset clears the phase, counters, queue and output valid; no clearing pass.
// A stalled output holds its result; the two-entry queue keeps taking input
// until it fills.
`default_nettype none

module xmodem_block_receiver_unit #(
  parameter int unsigned BLOCK_BYTES = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  xbr_in_if.sink           in_if,
  xbr_out_if.source        out_if
);

  xbr_pkg::cfg_t  cfg_q, cfg_d;
  xbr_pkg::item_t item;
  xbr_pkg::res_t  res;
  logic           item_valid;
  logic           item_pop;
  logic           cfg_write;
  logic           reg_sel;

  // Config register file
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      case (reg_sel)
        xbr_pkg::REG_CRC_MODE: cfg_d.crc_mode        = pwdata[0];
        xbr_pkg::REG_TRIES:    cfg_d.handshake_tries = pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      xbr_pkg::REG_CRC_MODE: prdata = {31'd0, cfg_q.crc_mode};
      xbr_pkg::REG_TRIES:    prdata = {28'd0, cfg_q.handshake_tries};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_mode        <= 1'b1;
      cfg_q.handshake_tries <= 4'd6;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify
  xbr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .in_opcode_i  (in_if.opcode),
    .in_byte_i    (in_if.rx_byte),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back: protocol sequencer and output register
  xbr_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_valid_o  (out_if.valid),
    .res_o        (res),
    .res_ready_i  (out_if.ready)
  );

  assign out_if.tx_valid        = res.tx_valid;
  assign out_if.tx_byte         = res.tx_byte;
  assign out_if.data_valid      = res.data_valid;
  assign out_if.data_byte       = res.data_byte;
  assign out_if.data_is_padding = res.data_is_padding;
  assign out_if.block_end       = res.block_end;
  assign out_if.block_good      = res.block_good;
  assign out_if.block_number    = res.block_number;
  assign out_if.link_status     = res.link_status;

endmodule

`default_nettype wire
